// ===== rtl/stress_traction_projection_assert.svh =====
// Assertion macros used by the traction projection top level.
`ifndef STRESS_TRACTION_PROJECTION_ASSERT_SVH
`define STRESS_TRACTION_PROJECTION_ASSERT_SVH

// Same-cycle implication under the synchronous active-low reset.
`define STP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stp: assertion failed");

// Next-cycle implication under the synchronous active-low reset.
`define STP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stp: assertion failed");

`endif

// ===== rtl/stp_pkg.sv =====
`default_nettype none
package stp_pkg;

    localparam int WORD_W   = 32;
    localparam int NORM_W   = 18;
    localparam int NORM_FRAC = 16;
    localparam int ROOT_W   = 33;
    localparam int RAD_W    = 64;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     clip;
    } sat_t;

    // Clip a sign-extended value to signed 32 bits.
    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t s;
        if (v > 64'sd2147483647) begin
            s.value = 32'sh7FFF_FFFF;
            s.clip  = 1'b1;
        end else if (v < -64'sd2147483648) begin
            s.value = 32'sh8000_0000;
            s.clip  = 1'b1;
        end else begin
            s.value = v[31:0];
            s.clip  = 1'b0;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/stp_front.sv =====
`default_nettype none
module stp_front
    import stp_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire logic                     in_valid,
    input  wire logic signed [WORD_W-1:0] stress [9],
    input  wire logic signed [WORD_W-1:0] pore_pressure,
    input  wire logic [3*NORM_W-1:0]      unit_normal,
    output logic                          out_valid,
    output logic signed [WORD_W-1:0]      tang [3],
    output logic                          tang_clip,
    output sat_t                          normal_res
);

    logic [6:0] v_reg;

    logic signed [32:0] a_reg [9];
    logic signed [17:0] n1_reg [3], n2_reg [3], n3_reg [3], n4_reg [3], n5_reg [3];
    logic signed [50:0] pr_reg [9];
    logic signed [36:0] t3_reg [3], t4_reg [3], t5_reg [3], t6_reg [3];
    logic signed [54:0] tn_reg [3];
    logic signed [40:0] d5_reg, d6_reg;
    logic signed [58:0] dn_reg [3];
    logic signed [WORD_W-1:0] u_reg [3];
    logic uclip_reg;
    sat_t dres_reg;

    logic signed [52:0] acc_next [3];
    logic signed [56:0] dacc_next;
    logic signed [59:0] w_next [3];
    sat_t u_sat [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc_next[i] = 53'(pr_reg[3*i]) + 53'(pr_reg[3*i+1]) + 53'(pr_reg[3*i+2])
                          + 53'sd32768;
            w_next[i] = ($signed({{7{t6_reg[i][36]}}, t6_reg[i]}) <<< NORM_FRAC)
                        - 60'(dn_reg[i]) + 60'sd32768;
            u_sat[i] = sat32(64'($signed(w_next[i][59:16])));
        end
        dacc_next = 57'(tn_reg[0]) + 57'(tn_reg[1]) + 57'(tn_reg[2]) + 57'sd32768;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (i == j) begin
                        a_reg[3*i+j] <= 33'(stress[3*i+j]) - 33'(pore_pressure);
                    end else begin
                        a_reg[3*i+j] <= 33'(stress[3*i+j]);
                    end
                    pr_reg[3*i+j] <= 51'(a_reg[3*i+j]) * 51'(n1_reg[j]);
                end
                n1_reg[i] <= $signed(unit_normal[NORM_W*i +: NORM_W]);
                n2_reg[i] <= n1_reg[i];
                n3_reg[i] <= n2_reg[i];
                n4_reg[i] <= n3_reg[i];
                n5_reg[i] <= n4_reg[i];
                t3_reg[i] <= acc_next[i][52:16];
                tn_reg[i] <= 55'(t3_reg[i]) * 55'(n3_reg[i]);
                t4_reg[i] <= t3_reg[i];
                t5_reg[i] <= t4_reg[i];
                t6_reg[i] <= t5_reg[i];
                dn_reg[i] <= 59'(d5_reg) * 59'(n5_reg[i]);
                u_reg[i]  <= u_sat[i].value;
            end
            d5_reg    <= dacc_next[56:16];
            d6_reg    <= d5_reg;
            uclip_reg <= u_sat[0].clip | u_sat[1].clip | u_sat[2].clip;
            dres_reg  <= sat32(64'(d6_reg));
        end
    end

    assign out_valid  = v_reg[6];
    assign tang       = u_reg;
    assign tang_clip  = uclip_reg;
    assign normal_res = dres_reg;

endmodule
`default_nettype wire

// ===== rtl/stp_isqrt.sv =====
`default_nettype none
module stp_isqrt
    import stp_pkg::*;
#(
    parameter int SIDE_W = 34
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [RAD_W-1:0]  in_radicand,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      out_root,
    output logic [SIDE_W-1:0]      out_side
);

    // Bit-pair restoring square root, four steps per stage.
    localparam int STEPS  = 4;
    localparam int STAGES = RAD_W / (2 * STEPS);

    logic [RAD_W-1:0]  x_reg [STAGES];
    logic [RAD_W-1:0]  r_reg [STAGES];
    logic [SIDE_W-1:0] side_reg [STAGES];
    logic [STAGES-1:0] v_reg;
    logic [RAD_W-1:0]  x_in [STAGES];
    logic [RAD_W-1:0]  r_in [STAGES];
    logic [SIDE_W-1:0] side_in [STAGES];
    logic [RAD_W-1:0]  x_next [STAGES];
    logic [RAD_W-1:0]  r_next [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        if (g == 0) begin : g_first
            assign x_in[g]    = in_radicand;
            assign r_in[g]    = '0;
            assign side_in[g] = in_side;
        end else begin : g_rest
            assign x_in[g]    = x_reg[g-1];
            assign r_in[g]    = r_reg[g-1];
            assign side_in[g] = side_reg[g-1];
        end

        always_comb begin : p_steps
            logic [RAD_W-1:0] x;
            logic [RAD_W-1:0] r;
            logic [RAD_W-1:0] b;
            x = x_in[g];
            r = r_in[g];
            for (int k = 0; k < STEPS; k++) begin
                b = RAD_W'(1) << (RAD_W - 2 - 2 * (g * STEPS + k));
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
            end
            x_next[g] = x;
            r_next[g] = r;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[g]    <= x_next[g];
                r_reg[g]    <= r_next[g];
                side_reg[g] <= side_in[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[STAGES-2:0], in_valid};
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_root  = r_reg[STAGES-1][ROOT_W-1:0];
    assign out_side  = side_reg[STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/stress_traction_projection.sv =====
`default_nettype none
// Traction projection: each beat carries a 3x3 stress tensor, a pore pressure
// and a packed unit normal, and yields one beat holding either the normal
// traction t.n (normal_mode = 1) or the magnitude of the tangential traction
// (normal_mode = 0), saturated to signed 32 bits with a flag on any clipping.
// The pipeline accepts one beat per clock while the result side does not
// stall. Seven stages form the traction, the normal component and the
// tangential components, two stages square and sum, eight stages run the
// 64-bit square root at four bit-pairs per stage, and a final output
// register holds the result. A stall on the result side freezes the whole
// pipeline, so nothing is lost or repeated. The mode register must only be
// written while the pipeline holds no beats.
`include "stress_traction_projection_assert.svh"
module stress_traction_projection
    import stp_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic                     cfg_normal_mode,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic signed [WORD_W-1:0] s_stress_xx,
    input  wire logic signed [WORD_W-1:0] s_stress_xy,
    input  wire logic signed [WORD_W-1:0] s_stress_xz,
    input  wire logic signed [WORD_W-1:0] s_stress_yx,
    input  wire logic signed [WORD_W-1:0] s_stress_yy,
    input  wire logic signed [WORD_W-1:0] s_stress_yz,
    input  wire logic signed [WORD_W-1:0] s_stress_zx,
    input  wire logic signed [WORD_W-1:0] s_stress_zy,
    input  wire logic signed [WORD_W-1:0] s_stress_zz,
    input  wire logic signed [WORD_W-1:0] s_pore_pressure,
    input  wire logic [3*NORM_W-1:0]      s_unit_normal_packed,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [WORD_W-1:0]      m_projected_value,
    output logic                          m_saturated
);

    localparam int SIDE_W = WORD_W + 2;

    logic mode_reg;
    logic en;

    logic signed [WORD_W-1:0] stress [9];
    logic                     f_valid;
    logic signed [WORD_W-1:0] tang [3];
    logic                     tang_clip;
    sat_t                     normal_res;

    logic [RAD_W-1:0] sq_reg [3];
    logic [SIDE_W-1:0] side_sq_reg, side_sum_reg;
    logic [RAD_W-1:0] sum_reg;
    logic [1:0] v_reg;

    logic                     q_valid;
    logic [ROOT_W-1:0]        q_root;
    logic [SIDE_W-1:0]        q_side;

    logic                     out_valid_reg;
    logic signed [WORD_W-1:0] out_value_reg, out_value_next;
    logic                     out_flag_reg, out_flag_next;
    logic                     out_mode_reg;

    // The configuration register is always ready to take a beat.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            mode_reg <= cfg_normal_mode;
        end
    end

    // The whole pipeline advances together whenever the output register is
    // empty or being emptied.
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    assign stress[0] = s_stress_xx;
    assign stress[1] = s_stress_xy;
    assign stress[2] = s_stress_xz;
    assign stress[3] = s_stress_yx;
    assign stress[4] = s_stress_yy;
    assign stress[5] = s_stress_yz;
    assign stress[6] = s_stress_zx;
    assign stress[7] = s_stress_zy;
    assign stress[8] = s_stress_zz;

    stp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (s_valid),
        .stress        (stress),
        .pore_pressure (s_pore_pressure),
        .unit_normal   (s_unit_normal_packed),
        .out_valid     (f_valid),
        .tang          (tang),
        .tang_clip     (tang_clip),
        .normal_res    (normal_res)
    );

    // Squares of the clipped tangential components, then their sum. Each
    // square is at most 2^62, so the sum of three fits in 64 bits.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= RAD_W'(64'(tang[i]) * 64'(tang[i]));
            end
            side_sq_reg  <= {normal_res.value, normal_res.clip, tang_clip};
            sum_reg      <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            side_sum_reg <= side_sq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[0], f_valid};
        end
    end

    stp_isqrt #(
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (v_reg[1]),
        .in_radicand (sum_reg),
        .in_side     (side_sum_reg),
        .out_valid   (q_valid),
        .out_root    (q_root),
        .out_side    (q_side)
    );

    // Pick the result for the current mode. The root can reach 2^31 or
    // beyond, in which case it is clipped.
    always_comb begin
        if (mode_reg) begin
            out_value_next = q_side[SIDE_W-1:2];
            out_flag_next  = q_side[1];
        end else if (q_root[ROOT_W-1:WORD_W-1] != '0) begin
            out_value_next = 32'sh7FFF_FFFF;
            out_flag_next  = 1'b1;
        end else begin
            out_value_next = $signed(q_root[WORD_W-1:0]);
            out_flag_next  = q_side[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_value_reg <= out_value_next;
            out_flag_reg  <= out_flag_next;
            out_mode_reg  <= mode_reg;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_projected_value = out_value_reg;
    assign m_saturated       = out_flag_reg;

    // A waiting result must hold the input side off.
    `STP_ASSERT_NOW(a_stall_blocks_input, aclk, aresetn, m_valid && !m_ready, !s_ready)
    // An accepted beat always enters the first stage.
    `STP_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, u_front.v_reg[0])
    // A tangential magnitude is never negative.
    `STP_ASSERT_NOW(a_magnitude_sign, aclk, aresetn, out_valid_reg && !out_mode_reg,
                    !out_value_reg[WORD_W-1])

endmodule
`default_nettype wire
